// File: rtl/vcd_pkg.sv
// ----------------------------------------------------------------------------
// vcd_pkg: shared types and constants for the vibration cycle detector
// Register map indexes, machine states, labels, sequencer phases, config and ring sizing.
// ----------------------------------------------------------------------------
package vcd_pkg;

  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = 16 + FILL_W;
  localparam int PADDR_W    = 6;

  // register indexes
  localparam logic [2:0] REG_ACTIVITY = 3'd0;
  localparam logic [2:0] REG_QUIET    = 3'd1;
  localparam logic [2:0] REG_CLASS    = 3'd2;
  localparam logic [2:0] REG_CONFIRM  = 3'd3;
  localparam logic [2:0] REG_DONEQ    = 3'd4;
  localparam logic [2:0] REG_MINRUN   = 3'd5;
  localparam logic [2:0] REG_HANDOFF  = 3'd6;
  localparam logic [2:0] REG_SMOOTH   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_CONFIRM = 3'd1,
    ST_RUN     = 3'd2,
    ST_QUIET   = 3'd3,
    ST_DONE    = 3'd4
  } det_state_t;

  typedef enum logic [1:0] {
    LB_UNKNOWN = 2'd0,
    LB_WASHER  = 2'd1,
    LB_DRYER   = 2'd2,
    LB_STACK   = 2'd3
  } label_t;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE, PH_SUM, PH_DIV, PH_FSM, PH_OUT
  } phase_t;

  typedef struct packed {
    logic [31:0] activity;
    logic [15:0] quiet_rms;
    logic [31:0] class_thr;
    logic [63:0] confirm;
    logic [31:0] done_quiet;
    logic [63:0] min_run;
    logic [31:0] handoff;
    logic [3:0]  smooth;
  } cfg_t;

endpackage

// File: rtl/vcd_if.sv
// ----------------------------------------------------------------------------
// vcd_win_if / vcd_res_if: valid/ready channels for windows and results
// One transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vcd_win_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [15:0] rms_level;
  logic [15:0] peak_level;
  modport source (output valid, time_ms, rms_level, peak_level, input ready);
  modport sink (input valid, time_ms, rms_level, peak_level, output ready);
endinterface

interface vcd_res_if;
  logic       valid;
  logic       ready;
  logic       post_done;
  logic [2:0] detector_state;
  logic [1:0] cycle_label;
  modport source (output valid, post_done, detector_state, cycle_label, input ready);
  modport sink (input valid, post_done, detector_state, cycle_label, output ready);
endinterface

// File: rtl/vibration_cycle_detector_core.sv
// ----------------------------------------------------------------------------
// vibration_cycle_detector_core: washer/dryer cycle detector
// Smooths motion windows and tracks a laundry cycle state machine.
// ----------------------------------------------------------------------------
// Usage:
//  win (sink) takes one window: time_ms, rms_level, peak_level.
//  res (source) gives one result per window: post_done, detector_state,
//  cycle_label. Configuration is written through the APB port.
//  After the window transfer the result is built in steps, N being the
//  windows averaged (1..8): one ring entry per cycle through the shared
//  accumulator, the bit-serial divider, the hand-over to the state machine
//  and one state update; res.valid is then raised.
//  win.ready is low from acceptance until the result has been taken, so no
//  new window is accepted while a result is still pending.
//  A stalled receiver simply holds the result valid; nothing is lost.
//  Reset (rst, synchronous) restores register defaults, an empty ring
//  and the idle state; ring contents are not cleared.
// ----------------------------------------------------------------------------
module vibration_cycle_detector_core import vcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  vcd_win_if.sink            win,
  vcd_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  cfg_t        cfg;
  phase_t      ph, ph_next;
  logic [31:0] t_hold;
  logic        start, avg_done, fsm_step, drop, post;
  logic [15:0] rms_avg, peak_avg;
  det_state_t  st;
  label_t      lb;

  vcd_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .pready, .cfg);

  assign start    = win.valid & win.ready;
  assign fsm_step = (ph == PH_FSM);

  vcd_avg u_avg (.clk, .rst, .start, .clear(drop & fsm_step),
                 .rms_in(win.rms_level), .peak_in(win.peak_level),
                 .smooth(cfg.smooth), .done(avg_done), .rms_avg, .peak_avg);

  vcd_fsm u_fsm (.clk, .rst, .step(fsm_step), .t(t_hold), .rms(rms_avg),
                 .peak(peak_avg), .cfg, .drop, .post, .state(st), .label(lb));

  always_ff @(posedge clk) begin
    if (start) t_hold <= win.time_ms;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) ph <= PH_IDLE;
    else     ph <= ph_next;
  end

  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_IDLE: if (win.valid) ph_next = PH_SUM;
      PH_SUM:  if (avg_done) ph_next = PH_FSM;
      PH_FSM:  ph_next = PH_OUT;
      PH_OUT:  if (res.ready) ph_next = PH_IDLE;
      default: ph_next = PH_IDLE;
    endcase
  end

  assign win.ready          = (ph == PH_IDLE);
  assign res.valid          = (ph == PH_OUT);
  assign res.post_done      = post;
  assign res.detector_state = st;
  assign res.cycle_label    = lb;

endmodule

// File: rtl/vcd_regs.sv
// ----------------------------------------------------------------------------
// vcd_regs: APB configuration register file
// Eight registers at 8-byte spacing; writes masked to register width.
// ----------------------------------------------------------------------------
module vcd_regs import vcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;
  logic       hit;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];
  assign hit    = (paddr[2:0] == 3'd0);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.activity   <= 32'd4718624;
      cfg.quiet_rms  <= 16'd16;
      cfg.class_thr  <= 32'd52428928;
      cfg.confirm    <= 64'd128849018910000;
      cfg.done_quiet <= 32'd300000;
      cfg.min_run    <= 64'd2576980378200000;
      cfg.handoff    <= 32'd3600000;
      cfg.smooth     <= 4'd1;
    end else if (wr && hit) begin
      unique case (idx)
        REG_ACTIVITY: cfg.activity   <= pwdata[31:0];
        REG_QUIET:    cfg.quiet_rms  <= pwdata[15:0];
        REG_CLASS:    cfg.class_thr  <= pwdata[31:0];
        REG_CONFIRM:  cfg.confirm    <= pwdata;
        REG_DONEQ:    cfg.done_quiet <= pwdata[31:0];
        REG_MINRUN:   cfg.min_run    <= pwdata;
        REG_HANDOFF:  cfg.handoff    <= pwdata[31:0];
        REG_SMOOTH:   cfg.smooth     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ACTIVITY: prdata = {32'd0, cfg.activity};
      REG_QUIET:    prdata = {48'd0, cfg.quiet_rms};
      REG_CLASS:    prdata = {32'd0, cfg.class_thr};
      REG_CONFIRM:  prdata = cfg.confirm;
      REG_DONEQ:    prdata = {32'd0, cfg.done_quiet};
      REG_MINRUN:   prdata = cfg.min_run;
      REG_HANDOFF:  prdata = {32'd0, cfg.handoff};
      REG_SMOOTH:   prdata = {60'd0, cfg.smooth};
      default:      prdata = '0;
    endcase
    if (!hit) prdata = '0;
  end

endmodule

// File: rtl/vcd_avg.sv
// ----------------------------------------------------------------------------
// vcd_avg: ring store and iterative averager
// Writes the window, accumulates the last N entries one per cycle, then
// divides both sums by N with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vcd_avg import vcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              clear,
  input  logic [15:0]       rms_in,
  input  logic [15:0]       peak_in,
  input  logic [3:0]        smooth,
  output logic              done,
  output logic [15:0]       rms_avg,
  output logic [15:0]       peak_avg
);

  logic [15:0]        rms_mem [RING_DEPTH];
  logic [15:0]        peak_mem [RING_DEPTH];
  logic [RING_AW-1:0] wpos, rpos;
  logic [FILL_W-1:0]  fill, count, k;
  logic [SUM_W-1:0]   rs, ps;
  logic [FILL_W-1:0]  rrem, prem;
  logic [4:0]         bitn;
  logic               sum_on, div_on;
  logic [FILL_W-1:0]  desired;
  logic [FILL_W-1:0]  fill_new;
  logic [FILL_W:0]    rtry, ptry;

  // clamp the smoothing count to 1..RING_DEPTH, then to the fill
  always_comb begin
    if (smooth == 4'd0) desired = FILL_W'(1);
    else if ({1'b0, smooth} > 5'(RING_DEPTH)) desired = FILL_W'(RING_DEPTH);
    else desired = FILL_W'(smooth);
    fill_new = (fill < FILL_W'(RING_DEPTH)) ? fill + 1'b1 : fill;
    rtry = {rrem, rs[SUM_W-1]} ;
    ptry = {prem, ps[SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rms_mem[wpos]  <= rms_in;
      peak_mem[wpos] <= peak_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0; fill <= '0; sum_on <= 1'b0; div_on <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        wpos <= '0;
        fill <= '0;
      end else if (start) begin
        wpos   <= RING_AW'((32'(wpos) + 1) % RING_DEPTH);
        fill   <= fill_new;
        rpos   <= wpos;
        count  <= (fill_new < desired) ? fill_new : desired;
        k      <= '0;
        rs     <= '0;
        ps     <= '0;
        sum_on <= 1'b1;
      end else if (sum_on) begin
        // one ring entry per cycle, newest first
        rs   <= rs + SUM_W'(rms_mem[rpos]);
        ps   <= ps + SUM_W'(peak_mem[rpos]);
        rpos <= (rpos == '0) ? RING_AW'(RING_DEPTH - 1) : rpos - 1'b1;
        k    <= k + 1'b1;
        if (k + 1'b1 == count) begin
          sum_on <= 1'b0;
          div_on <= 1'b1;
          bitn   <= 5'(SUM_W);
          rrem   <= '0;
          prem   <= '0;
        end
      end else if (div_on) begin
        // restoring division, quotient shifts into the sum registers
        if (rtry >= {1'b0, count}) begin
          rrem <= FILL_W'(rtry - {1'b0, count});
          rs   <= {rs[SUM_W-2:0], 1'b1};
        end else begin
          rrem <= rtry[FILL_W-1:0];
          rs   <= {rs[SUM_W-2:0], 1'b0};
        end
        if (ptry >= {1'b0, count}) begin
          prem <= FILL_W'(ptry - {1'b0, count});
          ps   <= {ps[SUM_W-2:0], 1'b1};
        end else begin
          prem <= ptry[FILL_W-1:0];
          ps   <= {ps[SUM_W-2:0], 1'b0};
        end
        bitn <= bitn - 1'b1;
        if (bitn == 5'd1) begin
          div_on <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rms_avg  = rs[15:0];
  assign peak_avg = ps[15:0];

endmodule

// File: rtl/vcd_fsm.sv
// ----------------------------------------------------------------------------
// vcd_fsm: cycle state machine and labelling
// Runs once per averaged window; updates cycle state in one step.
// ----------------------------------------------------------------------------
module vcd_fsm import vcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [31:0] t,
  input  logic [15:0] rms,
  input  logic [15:0] peak,
  input  cfg_t        cfg,
  output logic        drop,
  output logic        post,
  output det_state_t  state,
  output label_t      label
);

  det_state_t  state_next;
  label_t      label_next, last_label, last_label_next;
  logic [31:0] cstart, cstart_next, qstart, qstart_next, rstart, rstart_next;
  logic [31:0] ltime, ltime_next, need, rs_eff;
  logic        spin, spin_next, dry, dry_next, post_next;
  logic        act, quiet, spin_hit, dry_hit;

  always_comb begin
    act      = (rms >= cfg.activity[15:0]) || (peak >= cfg.activity[31:16]);
    quiet    = rms <= cfg.quiet_rms;
    spin_hit = peak >= cfg.class_thr[31:16];
    dry_hit  = rms <= cfg.class_thr[15:0];
    need     = (label == LB_DRYER) ? cfg.min_run[63:32] : cfg.min_run[31:0];
    rs_eff   = (rstart == 32'd0) ? t : rstart;

    state_next = state; label_next = label; last_label_next = last_label;
    cstart_next = cstart; qstart_next = qstart; rstart_next = rstart;
    ltime_next = ltime; spin_next = spin; dry_next = dry;
    post_next = 1'b0; drop = 1'b0;

    unique case (state)
      ST_IDLE, ST_DONE: begin
        if (act) begin
          state_next = ST_CONFIRM; label_next = LB_UNKNOWN;
          cstart_next = t; qstart_next = '0; rstart_next = '0;
          spin_next = spin_hit; dry_next = dry_hit;
        end
      end
      ST_CONFIRM: begin
        if (act) begin
          spin_next = spin | spin_hit; dry_next = dry | dry_hit;
          if (t - cstart >= cfg.confirm[31:0]) state_next = ST_RUN;
        end else begin
          drop = 1'b1;
          state_next = ST_IDLE; label_next = LB_UNKNOWN;
          cstart_next = '0; qstart_next = '0; rstart_next = '0;
          spin_next = 1'b0; dry_next = 1'b0;
        end
      end
      ST_RUN: begin
        if (act) begin
          spin_next = spin | spin_hit; dry_next = dry | dry_hit;
        end else if (quiet) begin
          qstart_next = t; rstart_next = '0; state_next = ST_QUIET;
          if (spin) label_next = LB_WASHER;
          else if (last_label == LB_WASHER && (t - ltime) <= cfg.handoff && dry)
            label_next = LB_DRYER;
          else label_next = LB_STACK;
        end
      end
      ST_QUIET: begin
        if (act) begin
          rstart_next = rs_eff;
          if (t - rs_eff >= cfg.confirm[63:32]) begin
            spin_next = spin | spin_hit; dry_next = dry | dry_hit;
            rstart_next = '0; state_next = ST_RUN;
          end
        end else if (quiet) begin
          rstart_next = '0;
          if ((t - qstart >= cfg.done_quiet) && (t - cstart >= need)) begin
            state_next = ST_DONE; last_label_next = label;
            ltime_next = t; post_next = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; label <= LB_UNKNOWN; last_label <= LB_UNKNOWN;
      cstart <= '0; qstart <= '0; rstart <= '0; ltime <= '0;
      spin <= 1'b0; dry <= 1'b0; post <= 1'b0;
    end else if (step) begin
      state <= state_next; label <= label_next; last_label <= last_label_next;
      cstart <= cstart_next; qstart <= qstart_next; rstart <= rstart_next;
      ltime <= ltime_next; spin <= spin_next; dry <= dry_next; post <= post_next;
    end
  end

endmodule
